FILE: hdl/ndcc_pkg.sv
package ndcc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;

   localparam int CHAR_W    = 16;
   localparam int CLASS_W   = 3;
   localparam int DEPTH_W   = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAR_W-1:0] OPEN_CHAR_RESET  = 16'd91;
   localparam logic [CHAR_W-1:0] CLOSE_CHAR_RESET = 16'd93;
   localparam logic [CHAR_W-1:0] CORE_CHAR_RESET  = 16'd126;

   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_CHAR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_CHAR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_CHAR  = 2'd2;

   typedef enum logic [1:0] {
      TOK_OPEN   = 2'd0,
      TOK_CDELIM = 2'd1,
      TOK_CORE   = 2'd2
   } tok_type;

   typedef enum logic [CLASS_W-1:0] {
      CLS_PAD_DELIM  = 3'd0,
      CLS_CORE_DELIM = 3'd1,
      CLS_PREFIX     = 3'd2,
      CLS_CORE_TEXT  = 3'd3,
      CLS_POSTFIX    = 3'd4,
      CLS_PLAIN      = 3'd5
   } class_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

FILE: hdl/nested_delimiter_char_classifier.sv
// Channel | Direction | Handshake               | Word
// --------+-----------+-------------------------+-------------------------------------
// req     | in        | req_valid / req_stall   | req_ch[15:0], req_clear
// rsp     | out       | rsp_valid / rsp_stall   | rsp_char_class[2:0], rsp_depth[5:0],
//         |           |                         | rsp_overflow
// csr     | in        | csr_valid / csr_ready   | csr_index[1:0], csr_wdata[15:0]
//
// The stack memory is read at the accepting edge; the update (and any push
// write) is made from the EXEC state once the output register is free.
// Reset empties the stack by clearing the count and open-pad pointer; the
// memory itself is not cleared and needs no clearing pass.
// A new word is taken while a result waits on rsp; that word then holds in
// the update cycle until the output register frees.
// csr_ready is always high; write registers only while the block is idle.
module nested_delimiter_char_classifier #(
   parameter int STACK_DEPTH = ndcc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ndcc_pkg::CHAR_W-1:0]       req_ch,
   input  logic                              req_clear,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ndcc_pkg::CLASS_W-1:0]      rsp_char_class,
   output logic [ndcc_pkg::DEPTH_W-1:0]      rsp_depth,
   output logic                              rsp_overflow,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ndcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ndcc_pkg::CHAR_W-1:0]       csr_wdata
);

   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int CW    = $clog2(STACK_DEPTH + 1);
   localparam int ENT_W = 2 + CW;

   // entry: token below this one, open-pad pointer before this push
   logic [ENT_W-1:0] stack_mem [STACK_DEPTH];

   ndcc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       open_top_ff, open_top_in;
   ndcc_pkg::tok_type   top_ff, top_in;

   logic [ndcc_pkg::CHAR_W-1:0] open_char_ff, close_char_ff, core_char_ff;
   logic [ndcc_pkg::CHAR_W-1:0] ch_ff;
   logic                        clear_ff;
   logic [ENT_W-1:0]            rd_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   ndcc_pkg::class_type           cls_ff, cls_in;
   logic [ndcc_pkg::DEPTH_W-1:0]  depth_ff, depth_in;
   logic                          ovf_ff, ovf_in;

   logic             accept;
   logic             go;
   logic [CW-1:0]    eff_count;
   logic [CW-1:0]    eff_open;
   logic             full;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic [AW-1:0]    rd_addr;
   ndcc_pkg::tok_type rd_below;
   logic [CW-1:0]    rd_prev;

   assign req_stall = (state_ff != ndcc_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign go        = (state_ff == ndcc_pkg::ST_EXEC) && !(rsp_valid_ff && rsp_stall);
   assign csr_ready = 1'b1;

   assign rd_addr  = AW'(open_top_ff - 1'b1);
   assign rd_below = ndcc_pkg::tok_type'(rd_ff[ENT_W-1:CW]);
   assign rd_prev  = rd_ff[CW-1:0];

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_class = cls_ff;
   assign rsp_depth      = depth_ff;
   assign rsp_overflow   = ovf_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ndcc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ndcc_pkg::ST_EXEC;
            end
         end
         ndcc_pkg::ST_EXEC: begin
            if (go) begin
               state_in = ndcc_pkg::ST_IDLE;
            end
         end
         default: state_in = ndcc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      eff_count = clear_ff ? '0 : count_ff;
      eff_open  = clear_ff ? '0 : open_top_ff;
      full      = (eff_count == CW'(STACK_DEPTH));

      count_in    = eff_count;
      open_top_in = eff_open;
      top_in      = top_ff;
      ovf_in      = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = eff_count[AW-1:0];
      wr_data     = {top_ff, eff_open};
      cls_in      = ndcc_pkg::CLS_PLAIN;

      if (ch_ff == open_char_ff) begin
         cls_in = ndcc_pkg::CLS_PAD_DELIM;
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            wr_en       = 1'b1;
            count_in    = CW'(eff_count + 1'b1);
            open_top_in = CW'(eff_count + 1'b1);
            top_in      = ndcc_pkg::TOK_OPEN;
         end
      end else if (ch_ff == close_char_ff) begin
         cls_in = ndcc_pkg::CLS_PAD_DELIM;
         // cut at the innermost open pad, drop it and all above
         if (eff_open != '0) begin
            count_in    = CW'(eff_open - 1'b1);
            open_top_in = rd_prev;
            top_in      = rd_below;
         end
      end else if (ch_ff == core_char_ff) begin
         cls_in = ndcc_pkg::CLS_CORE_DELIM;
         if ((eff_count != '0) && (top_ff == ndcc_pkg::TOK_CDELIM)) begin
            top_in = ndcc_pkg::TOK_CORE;
         end else if (full) begin
            ovf_in = 1'b1;
         end else begin
            wr_en    = 1'b1;
            count_in = CW'(eff_count + 1'b1);
            top_in   = ndcc_pkg::TOK_CDELIM;
         end
      end else if (eff_count == '0) begin
         cls_in = ndcc_pkg::CLS_PLAIN;
      end else begin
         case (top_ff)
            ndcc_pkg::TOK_OPEN:   cls_in = ndcc_pkg::CLS_PREFIX;
            ndcc_pkg::TOK_CDELIM: cls_in = ndcc_pkg::CLS_CORE_TEXT;
            default:              cls_in = ndcc_pkg::CLS_POSTFIX;
         endcase
      end

      depth_in = ndcc_pkg::DEPTH_W'(count_in);
   end

   always_comb begin
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ndcc_pkg::ST_IDLE;
         count_ff      <= '0;
         open_top_ff   <= '0;
         top_ff        <= ndcc_pkg::TOK_OPEN;
         rsp_valid_ff  <= 1'b0;
         open_char_ff  <= ndcc_pkg::OPEN_CHAR_RESET;
         close_char_ff <= ndcc_pkg::CLOSE_CHAR_RESET;
         core_char_ff  <= ndcc_pkg::CORE_CHAR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            count_ff    <= count_in;
            open_top_ff <= open_top_in;
            top_ff      <= top_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ndcc_pkg::CSR_OPEN_CHAR:  open_char_ff  <= csr_wdata;
               ndcc_pkg::CSR_CLOSE_CHAR: close_char_ff <= csr_wdata;
               ndcc_pkg::CSR_CORE_CHAR:  core_char_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // hold the word and fetch the innermost open-pad entry
   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff    <= req_ch;
         clear_ff <= req_clear;
         rd_ff    <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (go && wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         cls_ff   <= cls_in;
         depth_ff <= depth_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule
